>>> src/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// No dependencies.
`default_nettype none
package b2da_pkg;

	localparam logic [7:0] ASCII_ZERO    = 8'd48;
	localparam logic [7:0] ASCII_NEWLINE = 8'd10;
	localparam int unsigned QDEPTH       = 2;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIGIT,
		B_NL
	} back_state_t;

endpackage
`default_nettype wire

>>> src/b2da_front.sv
// Front end: takes one binary value and converts it to BCD, one bit per cycle.
// Depends on b2da_pkg.
`default_nettype none
module b2da_front #(
	parameter int unsigned W  = 32,
	parameter int unsigned ND = 10,
	parameter int unsigned IW = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [W-1:0]         in_value,
	output logic                      push,
	input  wire logic                 q_full,
	output logic [4*ND+IW-1:0]        push_data
);
	import b2da_pkg::*;

	localparam int unsigned BW = 4 * ND;
	localparam int unsigned CW = (W > 2) ? $clog2(W) : 1;

	front_state_t     state_q, state_n;
	logic [W-1:0]     bin_q;
	logic [BW-1:0]    bcd_q;
	logic [BW-1:0]    bcd_adj;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    top_idx;
	logic             accept;
	logic             shift_en;

	assign accept   = in_valid && in_ready;
	assign shift_en = (state_q == F_CONV);

	always_comb begin
		state_n  = state_q;
		in_ready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_n = F_CONV;
			end
			F_CONV: begin
				if (cnt_q == CW'(W - 1)) state_n = F_PUSH;
			end
			F_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_n = F_IDLE;
				end
			end
			default: state_n = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// add-3 correction on every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			else bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= in_value;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (shift_en) begin
			bcd_q <= {bcd_adj[BW-2:0], bin_q[W-1]};
			bin_q <= {bin_q[W-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// highest nonzero digit; zero value keeps the single '0'
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) top_idx = IW'(i);
		end
	end

	assign push_data = {top_idx, bcd_q};

endmodule
`default_nettype wire

>>> src/b2da_queue.sv
// Short queue of converted numbers between front and back.
// Depends on b2da_pkg.
`default_nettype none
module b2da_queue #(
	parameter int unsigned EW = 44
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic [EW-1:0] wdata,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output logic [EW-1:0]      rdata
);
	import b2da_pkg::*;

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned NW = $clog2(QDEPTH + 1);

	logic [EW-1:0] mem_q [QDEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop) rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> src/b2da_back.sv
// Back end: walks the BCD digits from the top and sends ASCII bytes, then newline.
// Depends on b2da_pkg.
`default_nettype none
module b2da_back #(
	parameter int unsigned ND = 10,
	parameter int unsigned IW = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire logic [4*ND+IW-1:0] q_data,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_byte,
	output logic                   out_last
);
	import b2da_pkg::*;

	localparam int unsigned BW = 4 * ND;

	back_state_t   state_q, state_n;
	logic [BW-1:0] digits_q;
	logic [IW-1:0] idx_q;
	logic [3:0]    cur_digit;
	logic          out_load;
	logic          slot_free;
	logic          valid_q;
	logic [7:0]    byte_q;
	logic          last_q;

	assign slot_free = !valid_q || out_ready;
	assign cur_digit = digits_q[4*idx_q +: 4];

	always_comb begin
		state_n  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_n = B_DIGIT;
				end
			end
			B_DIGIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					if (idx_q == '0) state_n = B_NL;
				end
			end
			B_NL: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_n  = B_IDLE;
				end
			end
			default: state_n = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (out_load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			digits_q <= q_data[BW-1:0];
			idx_q    <= q_data[BW +: IW];
		end else if (out_load && state_q == B_DIGIT) begin
			idx_q <= idx_q - 1'b1;
		end
		if (out_load) begin
			byte_q <= (state_q == B_DIGIT) ? ASCII_ZERO + {4'd0, cur_digit} : ASCII_NEWLINE;
			last_q <= (state_q == B_NL);
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

>>> src/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter.
// Depends on b2da_pkg, b2da_front, b2da_queue, b2da_back.
//
//   channel  dir  tdata                 tuser  tlast
//   s_axis   in   value                 -      -
//   m_axis   out  char_byte             -      last (newline byte)
//
// Front: accepts a value, runs shift-add-3 over its VALUE_WIDTH bits, then queues it.
// Back: fetches from the queue, then sends one byte per digit and one for newline.
// The front takes no new value until the last one is queued.
// Two converted values can wait in the queue while the output stalls.
// Reset clears all control state; no clearing pass is needed.
`default_nettype none
module binary_to_decimal_ascii_core #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // value
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic [7:0]                                 m_axis_tdata,  // char_byte
	output logic                                       m_axis_tlast
);
	import b2da_pkg::*;

	localparam int unsigned ND = (VALUE_WIDTH * 30103 + 99999) / 100000;
	localparam int unsigned IW = (ND > 1) ? $clog2(ND) : 1;
	localparam int unsigned EW = 4 * ND + IW;

	logic          push, pop, q_full, q_empty;
	logic [EW-1:0] push_data, q_data;

	b2da_front #(
		.W (VALUE_WIDTH),
		.ND(ND),
		.IW(IW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_value (s_axis_tdata[VALUE_WIDTH-1:0]),
		.push     (push),
		.q_full   (q_full),
		.push_data(push_data)
	);

	b2da_queue #(
		.EW(EW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_data),
		.full  (q_full),
		.pop   (pop),
		.empty (q_empty),
		.rdata (q_data)
	);

	b2da_back #(
		.ND(ND),
		.IW(IW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_byte (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for binary_to_decimal_ascii_core: decimal ASCII output per value.
// Drives a directed table, then random values, with random idling on both stream sides.
// Depends on b2da_pkg and binary_to_decimal_ascii_core.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import b2da_pkg::*;

	localparam int unsigned VALUE_WIDTH = 32;
	localparam int unsigned RANDOM_ITEMS = 210;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       last;
	} ascii_beat_t;

	typedef struct {
		logic [31:0] value;
		string       text;  // empty: use the decimal predictor
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // value
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;       // char_byte
	logic        m_axis_tlast;

	ascii_beat_t pending_chars[$];
	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	int unsigned rx_hold = 0;

	stim_row_t directed[] = '{
		'{32'd0,          "0"},
		'{32'hFFFF_FFFF,  "4294967295"},
		'{32'd1,          "1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'd99,         ""},
		'{32'd100,        ""},
		'{32'd101,        ""},
		'{32'd999_999_999, ""},
		'{32'd1_000_000_000, ""},
		'{32'hFFFF_FFFE,  ""},
		'{32'h8000_0000,  ""},
		'{32'h7FFF_FFFF,  ""},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'd12345,      ""},
		'{32'd65535,      ""},
		'{32'd1_000_000,  ""},
		'{32'd0,          "0"},
		'{32'd4_000_000_000, ""}
	};

	binary_to_decimal_ascii_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void predict_decimal(input logic [31:0] value);
		logic [7:0]  digit_stack[$];
		logic [31:0] rest;
		rest = value;
		do begin
			digit_stack.push_front(ASCII_ZERO + 8'(rest % 32'd10));
			rest = rest / 32'd10;
		end while (rest != 0);
		foreach (digit_stack[i])
			pending_chars.push_back('{char_byte: digit_stack[i], last: 1'b0});
		pending_chars.push_back('{char_byte: ASCII_NEWLINE, last: 1'b1});
	endfunction

	function automatic void queue_text(input string text);
		for (int i = 0; i < text.len(); i++)
			pending_chars.push_back('{char_byte: text[i], last: 1'b0});
		pending_chars.push_back('{char_byte: ASCII_NEWLINE, last: 1'b1});
	endfunction

	function automatic logic [31:0] pick_value();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] wide;
		int unsigned ndig;
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: begin
				ndig = $urandom_range(1, 10);
				lo = 64'd1;
				for (int i = 1; i < ndig; i++)
					lo = lo * 64'd10;
				hi = lo * 64'd10 - 64'd1;
				if (hi > 64'hFFFF_FFFF)
					hi = 64'hFFFF_FFFF;
				wide = {$urandom, $urandom};
				return 32'(lo + wide % (hi - lo + 64'd1));
			end
			2: return $urandom_range(0, 99);
			3: begin
				lo = 64'd1;
				ndig = $urandom_range(0, 9);
				for (int i = 0; i < ndig; i++)
					lo = lo * 64'd10;
				return 32'(lo + 64'($urandom_range(0, 2)) - 64'd1);
			end
			4: begin
				wide = 64'd1 << $urandom_range(0, 31);
				return $urandom_range(0, 1) ? ~32'(wide) : 32'(wide);
			end
			default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after the transfer, or after a random idle gap that follows it.
	task automatic send_value(input logic [31:0] value, input string text);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (text.len() != 0)
			queue_text(text);
		else
			predict_decimal(value);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (idle_on && rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				rx_hold = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		ascii_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected transfer: char_byte %0d last %0d", m_axis_tdata, m_axis_tlast);
				err_count++;
			end else begin
				want = pending_chars.pop_front();
				if (m_axis_tdata !== want.char_byte) begin
					$error("char_byte mismatch: expected %0d, actual %0d",
						want.char_byte, m_axis_tdata);
					err_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("binary_to_decimal_ascii_core verification failed");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_value(directed[i].value, directed[i].text);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			idle_on = (k < 180) && ((k / 35) % 3 != 1);
			if (k == 100) begin
				s_axis_tvalid <= 1'b0;
				while (pending_chars.size() != 0)
					@(negedge clk);
				repeat (3) @(negedge clk);
			end
			send_value(pick_value(), "");
		end
		s_axis_tvalid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0 && pending_chars.size() == 0)
			$display("binary_to_decimal_ascii_core verification clean");
		else
			$display("binary_to_decimal_ascii_core verification failed");
		$finish;
	end

endmodule
`default_nettype wire
